/* hw/rtl/dlle_pkg.sv */
// Shared constants, types and helpers of the doubly linked list engine.
package dlle_pkg;

	localparam int NODES = 256;
	localparam int IDX_W = (NODES > 1) ? $clog2(NODES) : 1;
	localparam int PTR_W = $clog2(NODES + 1);
	localparam int VAL_W = 32;
	localparam int OP_W = 5;
	localparam int S_TDATA_W = 40;
	localparam int M_TDATA_W = 40;
	localparam int S_PAD_W = S_TDATA_W - OP_W - VAL_W;
	localparam int M_PAD_W = M_TDATA_W - VAL_W - 2;

	// The link value NODES means "no node".
	localparam logic [PTR_W-1:0] NIL = PTR_W'(NODES);

	typedef enum logic [OP_W-1:0] {
		OP_CLEAR      = 5'd0,
		OP_INS_FIRST  = 5'd1,
		OP_INS_LAST   = 5'd2,
		OP_FIRST      = 5'd3,
		OP_LAST       = 5'd4,
		OP_GET_FIRST  = 5'd5,
		OP_GET_LAST   = 5'd6,
		OP_DEL_FIRST  = 5'd7,
		OP_DEL_LAST   = 5'd8,
		OP_DEL_AFTER  = 5'd9,
		OP_DEL_BEFORE = 5'd10,
		OP_INS_AFTER  = 5'd11,
		OP_INS_BEFORE = 5'd12,
		OP_GET        = 5'd13,
		OP_SET        = 5'd14,
		OP_NEXT       = 5'd15,
		OP_PREV       = 5'd16,
		OP_IS_ACTIVE  = 5'd17
	} op_t;

	typedef struct packed {
		logic             en;
		logic [IDX_W-1:0] addr;
		logic [PTR_W-1:0] data;
	} link_wr_t;

	typedef struct packed {
		logic             en;
		logic [IDX_W-1:0] addr;
		logic [VAL_W-1:0] data;
	} val_wr_t;

	typedef struct packed {
		logic [IDX_W-1:0] next_addr;
		logic [IDX_W-1:0] prev_addr;
		logic [IDX_W-1:0] val_addr;
	} rd_req_t;

	typedef struct packed {
		logic [PTR_W-1:0] nxt;
		logic [PTR_W-1:0] prv;
		logic [VAL_W-1:0] val;
	} rd_rsp_t;

	function automatic logic is_node(logic [PTR_W-1:0] p);
		return p < NIL;
	endfunction

	function automatic logic [IDX_W-1:0] to_idx(logic [PTR_W-1:0] p);
		return p[IDX_W-1:0];
	endfunction

endpackage

/* hw/rtl/dlle_node_store.sv */
// Node pool memories: value, next link and previous link, registered reads.
module dlle_node_store (
	input  logic               clk,
	input  dlle_pkg::rd_req_t  rd_req,
	output dlle_pkg::rd_rsp_t  rd_rsp,
	input  dlle_pkg::link_wr_t wr_next,
	input  dlle_pkg::link_wr_t wr_prev,
	input  dlle_pkg::val_wr_t  wr_val
);

	logic [dlle_pkg::PTR_W-1:0] next_mem [dlle_pkg::NODES];
	logic [dlle_pkg::PTR_W-1:0] prev_mem [dlle_pkg::NODES];
	logic [dlle_pkg::VAL_W-1:0] val_mem  [dlle_pkg::NODES];

	always_ff @(posedge clk) begin
		if (wr_next.en) begin
			next_mem[wr_next.addr] <= wr_next.data;
		end
		rd_rsp.nxt <= next_mem[rd_req.next_addr];
	end

	always_ff @(posedge clk) begin
		if (wr_prev.en) begin
			prev_mem[wr_prev.addr] <= wr_prev.data;
		end
		rd_rsp.prv <= prev_mem[rd_req.prev_addr];
	end

	always_ff @(posedge clk) begin
		if (wr_val.en) begin
			val_mem[wr_val.addr] <= wr_val.data;
		end
		rd_rsp.val <= val_mem[rd_req.val_addr];
	end

endmodule

/* hw/rtl/doubly_linked_list_engine.sv */
// Doubly linked list engine with a cursor over a pool of linked nodes.
//
// Each slave transaction carries one command (op in tdata[4:0], data in
// tdata[36:5]) and produces exactly one master transaction with the read
// value, an error flag and the cursor-valid flag. Commands cover clear,
// insert and delete at either end or around the cursor, cursor moves and
// reads and writes of node values.
// After its acceptance a command passes through S_RD2, in which the first
// read of the node memories returns, S_WR1, in which a second read that
// depends on it returns and the first writes are made, an optional second
// write-back state S_WR2, since each link memory has a single write port
// and some commands rewrite two links of the same memory, and S_OUT, which
// loads the output register. Commands are processed one at a time, so a
// new one is accepted only when the engine is back in S_IDLE.
// The result sits in an output register; a new command is accepted while
// an earlier result still waits, and it stalls in its final cycle until the
// receiver has taken the earlier one.
// Reset empties the list and the free list and restarts node allocation;
// the node memories are not cleared, because every node is written when it
// is allocated, before any read of it.
module doubly_linked_list_engine (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [39:0] s_axis_tdata,  // op[4:0], data[36:5], zero[39:37]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata   // value[31:0], error[32], active[33], zero[39:34]
);

	localparam int PW = dlle_pkg::PTR_W;
	localparam int VW = dlle_pkg::VAL_W;

	typedef enum logic [2:0] {
		S_IDLE,
		S_RD2,
		S_WR1,
		S_WR2,
		S_OUT
	} state_t;

	state_t state_q;

	// List pointers and allocator state.
	logic [PW-1:0] first_q, last_q, cur_q, free_q, fresh_q;

	// Current command and the results of its first read.
	dlle_pkg::op_t op_q;
	logic [VW-1:0] data_q;
	logic [PW-1:0] n1_q, p1_q;
	logic [VW-1:0] v_q;

	// Second write-back set and the pending result.
	dlle_pkg::link_wr_t w2_next_q, w2_prev_q;
	logic [VW-1:0] res_value_q;
	logic          res_error_q, res_active_q;

	logic                          m_valid_q;
	logic [dlle_pkg::M_TDATA_W-1:0] m_data_q;

	dlle_pkg::rd_req_t  rd_req;
	dlle_pkg::rd_rsp_t  rd_rsp;
	dlle_pkg::link_wr_t wr_next, wr_prev;
	dlle_pkg::val_wr_t  wr_val;

	dlle_pkg::op_t op_in;

	// Computed in the first write-back cycle.
	dlle_pkg::link_wr_t w1_next, w1_prev, w2_next, w2_prev;
	dlle_pkg::val_wr_t  w1_val;
	logic [PW-1:0] nf, nl, nc, nfree, nfresh;
	logic [VW-1:0] res_value;
	logic          res_error;
	logic          have_free, have_fresh, take_ok, commit_take;
	logic [PW-1:0] take_n, fnext;

	function automatic dlle_pkg::link_wr_t mk_link(logic [PW-1:0] a, logic [PW-1:0] d);
		dlle_pkg::link_wr_t r;
		r.en   = dlle_pkg::is_node(a);
		r.addr = dlle_pkg::to_idx(a);
		r.data = d;
		return r;
	endfunction

	function automatic dlle_pkg::val_wr_t mk_val(logic [PW-1:0] a, logic [VW-1:0] d);
		dlle_pkg::val_wr_t r;
		r.en   = dlle_pkg::is_node(a);
		r.addr = dlle_pkg::to_idx(a);
		r.data = d;
		return r;
	endfunction

	assign op_in         = dlle_pkg::op_t'(s_axis_tdata[dlle_pkg::OP_W-1:0]);
	assign s_axis_tready = (state_q == S_IDLE);
	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;

	// Read addresses: the first read is issued as the command is accepted,
	// the second one follows from the first read's data.
	always_comb begin
		rd_req = '0;
		if (state_q == S_IDLE) begin
			case (op_in) inside
				dlle_pkg::OP_INS_FIRST, dlle_pkg::OP_INS_LAST,
				dlle_pkg::OP_INS_BEFORE: rd_req.next_addr = dlle_pkg::to_idx(free_q);
				dlle_pkg::OP_DEL_FIRST:  rd_req.next_addr = dlle_pkg::to_idx(first_q);
				default:                 rd_req.next_addr = dlle_pkg::to_idx(cur_q);
			endcase
			case (op_in)
				dlle_pkg::OP_DEL_LAST: rd_req.prev_addr = dlle_pkg::to_idx(last_q);
				default:               rd_req.prev_addr = dlle_pkg::to_idx(cur_q);
			endcase
			case (op_in)
				dlle_pkg::OP_GET_FIRST: rd_req.val_addr = dlle_pkg::to_idx(first_q);
				dlle_pkg::OP_GET_LAST:  rd_req.val_addr = dlle_pkg::to_idx(last_q);
				default:                rd_req.val_addr = dlle_pkg::to_idx(cur_q);
			endcase
		end else if (state_q == S_RD2) begin
			// Node after the cursor's successor, or the free list's second entry.
			if (op_q == dlle_pkg::OP_DEL_AFTER) begin
				rd_req.next_addr = dlle_pkg::to_idx(rd_rsp.nxt);
			end else begin
				rd_req.next_addr = dlle_pkg::to_idx(free_q);
			end
			rd_req.prev_addr = dlle_pkg::to_idx(rd_rsp.prv);
		end
	end

	// Command evaluation. In S_WR1 the read port shows the second read.
	always_comb begin
		nf          = first_q;
		nl          = last_q;
		nc          = cur_q;
		nfree       = free_q;
		nfresh      = fresh_q;
		w1_next     = '0;
		w1_prev     = '0;
		w2_next     = '0;
		w2_prev     = '0;
		w1_val      = '0;
		res_value   = '0;
		res_error   = 1'b0;
		commit_take = 1'b0;

		// Allocation prefers the free list over never-used nodes.
		have_free  = dlle_pkg::is_node(free_q);
		have_fresh = fresh_q < dlle_pkg::NIL;
		take_ok    = have_free | have_fresh;
		take_n     = have_free ? free_q : fresh_q;
		fnext      = (op_q == dlle_pkg::OP_INS_AFTER) ? rd_rsp.nxt : n1_q;

		case (op_q)
			dlle_pkg::OP_CLEAR: begin
				nf     = dlle_pkg::NIL;
				nl     = dlle_pkg::NIL;
				nc     = dlle_pkg::NIL;
				nfree  = dlle_pkg::NIL;
				nfresh = '0;
			end
			dlle_pkg::OP_INS_FIRST: begin
				if (!take_ok) begin
					res_error = 1'b1;
				end else begin
					commit_take = 1'b1;
					w1_val  = mk_val(take_n, data_q);
					w1_next = mk_link(take_n, first_q);
					w1_prev = mk_link(take_n, dlle_pkg::NIL);
					if (dlle_pkg::is_node(first_q)) begin
						w2_prev = mk_link(first_q, take_n);
					end else begin
						nl = take_n;
					end
					nf = take_n;
				end
			end
			dlle_pkg::OP_INS_LAST: begin
				if (!take_ok) begin
					res_error = 1'b1;
				end else begin
					commit_take = 1'b1;
					w1_val  = mk_val(take_n, data_q);
					w1_next = mk_link(take_n, dlle_pkg::NIL);
					w1_prev = mk_link(take_n, last_q);
					if (dlle_pkg::is_node(last_q)) begin
						w2_next = mk_link(last_q, take_n);
					end else begin
						nf = take_n;
					end
					nl = take_n;
				end
			end
			dlle_pkg::OP_FIRST: nc = first_q;
			dlle_pkg::OP_LAST:  nc = last_q;
			dlle_pkg::OP_GET_FIRST, dlle_pkg::OP_GET_LAST: begin
				if (!dlle_pkg::is_node(first_q)) begin
					res_error = 1'b1;
				end else begin
					res_value = v_q;
				end
			end
			dlle_pkg::OP_DEL_FIRST: begin
				if (dlle_pkg::is_node(first_q)) begin
					if (cur_q == first_q) begin
						nc = dlle_pkg::NIL;
					end
					if (first_q == last_q) begin
						nf = dlle_pkg::NIL;
						nl = dlle_pkg::NIL;
					end else begin
						nf      = n1_q;
						w1_prev = mk_link(n1_q, dlle_pkg::NIL);
					end
					w2_next = mk_link(first_q, free_q);
					nfree   = first_q;
				end
			end
			dlle_pkg::OP_DEL_LAST: begin
				if (dlle_pkg::is_node(last_q)) begin
					if (cur_q == last_q) begin
						nc = dlle_pkg::NIL;
					end
					if (first_q == last_q) begin
						nf = dlle_pkg::NIL;
						nl = dlle_pkg::NIL;
					end else begin
						nl      = p1_q;
						w1_next = mk_link(p1_q, dlle_pkg::NIL);
					end
					w2_next = mk_link(last_q, free_q);
					nfree   = last_q;
				end
			end
			dlle_pkg::OP_DEL_AFTER: begin
				if (dlle_pkg::is_node(cur_q) && dlle_pkg::is_node(n1_q)) begin
					if (n1_q == last_q) begin
						w1_next = mk_link(cur_q, dlle_pkg::NIL);
						nl      = cur_q;
					end else begin
						w1_next = mk_link(cur_q, rd_rsp.nxt);
						w1_prev = mk_link(rd_rsp.nxt, cur_q);
					end
					w2_next = mk_link(n1_q, free_q);
					nfree   = n1_q;
				end
			end
			dlle_pkg::OP_DEL_BEFORE: begin
				if (dlle_pkg::is_node(cur_q) && dlle_pkg::is_node(p1_q)) begin
					w1_prev = mk_link(cur_q, rd_rsp.prv);
					if (p1_q == first_q) begin
						nf = cur_q;
					end else begin
						w1_next = mk_link(rd_rsp.prv, cur_q);
					end
					w2_next = mk_link(p1_q, free_q);
					nfree   = p1_q;
				end
			end
			dlle_pkg::OP_INS_AFTER: begin
				if (dlle_pkg::is_node(cur_q)) begin
					if (!take_ok) begin
						res_error = 1'b1;
					end else begin
						commit_take = 1'b1;
						w1_val  = mk_val(take_n, data_q);
						w1_prev = mk_link(take_n, cur_q);
						w1_next = mk_link(take_n, n1_q);
						if (cur_q == last_q) begin
							nl = take_n;
						end else begin
							w2_prev = mk_link(n1_q, take_n);
						end
						w2_next = mk_link(cur_q, take_n);
					end
				end
			end
			dlle_pkg::OP_INS_BEFORE: begin
				if (dlle_pkg::is_node(cur_q)) begin
					if (!take_ok) begin
						res_error = 1'b1;
					end else begin
						commit_take = 1'b1;
						w1_val  = mk_val(take_n, data_q);
						w1_prev = mk_link(take_n, p1_q);
						w1_next = mk_link(take_n, cur_q);
						if (cur_q == first_q) begin
							nf = take_n;
						end else begin
							w2_next = mk_link(p1_q, take_n);
						end
						w2_prev = mk_link(cur_q, take_n);
					end
				end
			end
			dlle_pkg::OP_GET: begin
				if (!dlle_pkg::is_node(cur_q)) begin
					res_error = 1'b1;
				end else begin
					res_value = v_q;
				end
			end
			dlle_pkg::OP_SET: w1_val = mk_val(cur_q, data_q);
			dlle_pkg::OP_NEXT: begin
				if (dlle_pkg::is_node(cur_q)) begin
					nc = n1_q;
				end
			end
			dlle_pkg::OP_PREV: begin
				if (dlle_pkg::is_node(cur_q)) begin
					nc = p1_q;
				end
			end
			default: begin
			end
		endcase

		if (commit_take) begin
			if (have_free) begin
				nfree = fnext;
			end else begin
				nfresh = fresh_q + PW'(1);
			end
		end
	end

	// Memory write ports: first set in S_WR1, registered second set in S_WR2.
	always_comb begin
		wr_next = '0;
		wr_prev = '0;
		wr_val  = '0;
		if (state_q == S_WR1) begin
			wr_next = w1_next;
			wr_prev = w1_prev;
			wr_val  = w1_val;
		end else if (state_q == S_WR2) begin
			wr_next = w2_next_q;
			wr_prev = w2_prev_q;
		end
	end

	dlle_node_store u_store (
		.clk     (clk),
		.rd_req  (rd_req),
		.rd_rsp  (rd_rsp),
		.wr_next (wr_next),
		.wr_prev (wr_prev),
		.wr_val  (wr_val)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			first_q      <= dlle_pkg::NIL;
			last_q       <= dlle_pkg::NIL;
			cur_q        <= dlle_pkg::NIL;
			free_q       <= dlle_pkg::NIL;
			fresh_q      <= '0;
			op_q         <= dlle_pkg::OP_CLEAR;
			data_q       <= '0;
			n1_q         <= '0;
			p1_q         <= '0;
			v_q          <= '0;
			w2_next_q    <= '0;
			w2_prev_q    <= '0;
			res_value_q  <= '0;
			res_error_q  <= 1'b0;
			res_active_q <= 1'b0;
			m_valid_q    <= 1'b0;
			m_data_q     <= '0;
		end else begin
			// In S_OUT the output register is reloaded by the state itself.
			if (m_valid_q && m_axis_tready && (state_q != S_OUT)) begin
				m_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (s_axis_tvalid) begin
						op_q    <= op_in;
						data_q  <= s_axis_tdata[dlle_pkg::OP_W +: VW];
						state_q <= S_RD2;
					end
				end
				S_RD2: begin
					n1_q    <= rd_rsp.nxt;
					p1_q    <= rd_rsp.prv;
					v_q     <= rd_rsp.val;
					state_q <= S_WR1;
				end
				S_WR1: begin
					first_q      <= nf;
					last_q       <= nl;
					cur_q        <= nc;
					free_q       <= nfree;
					fresh_q      <= nfresh;
					w2_next_q    <= w2_next;
					w2_prev_q    <= w2_prev;
					res_value_q  <= res_value;
					res_error_q  <= res_error;
					res_active_q <= dlle_pkg::is_node(nc);
					state_q      <= (w2_next.en || w2_prev.en) ? S_WR2 : S_OUT;
				end
				S_WR2: begin
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (!m_valid_q || m_axis_tready) begin
						m_valid_q <= 1'b1;
						m_data_q  <= {{dlle_pkg::M_PAD_W{1'b0}}, res_active_q, res_error_q,
							res_value_q};
						state_q   <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// The never-used node count cannot run past the pool.
	a_fresh_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fresh_q <= dlle_pkg::NIL)
		else $error("fresh node count beyond pool size");

	// Head and tail are either both present or both absent.
	a_ends_agree: assert property (@(posedge clk) disable iff (!arst_n)
		dlle_pkg::is_node(first_q) == dlle_pkg::is_node(last_q))
		else $error("list head and tail disagree on emptiness");

	// An accepted command always moves on to its dependent read cycle.
	a_accept_seq: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> (state_q == S_RD2) ##1 (state_q == S_WR1))
		else $error("command sequencing broken after acceptance");

	// The reported cursor flag matches the cursor just committed.
	a_active_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WR1) |=> (res_active_q == dlle_pkg::is_node(cur_q)))
		else $error("cursor-valid flag differs from the cursor");

endmodule
